@@ rtl/core/hough_line_accumulator_top_macros.svh @@
// assertion macros used by the top-level rtl
`ifndef HOUGH_LINE_ACCUMULATOR_TOP_MACROS_SVH
`define HOUGH_LINE_ACCUMULATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define HLA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define HLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HLA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define HLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/hla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hla_pkg;

  localparam int ANGLE_STEPS = 181;
  localparam int MAX_DIM     = 256;
  localparam int COUNT_W     = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  localparam logic [1:0] FUNC_VOTE  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic CFG_MARK_VALUE = 1'b0;
  localparam logic CFG_RHO_OFFSET = 1'b1;

  localparam logic [7:0] MARK_RESET   = 8'd255;
  localparam logic [9:0] OFFSET_RESET = 10'd362;

  // round(sin(k deg) * 65536), k = 0..90
  localparam int SIN_Q16 [0:90] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
    64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
    65536
  };

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } hla_state_t;

  typedef struct packed {
    logic       valid;
    logic       vote;
    logic       rd;
    logic [7:0] row;
    logic [7:0] col;
    logic [9:0] rho_index;
    logic [7:0] theta_index;
  } hla_tok_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } hla_res_t;

endpackage
`default_nettype wire

@@ rtl/core/hla_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface hla_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] pixel;
  logic [9:0] rho_index;
  logic [7:0] theta_index;
  modport source (output valid, func, row, col, pixel, rho_index, theta_index, input ready);
  modport sink (input valid, func, row, col, pixel, rho_index, theta_index, output ready);
endinterface

interface hla_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] count;
  modport source (output valid, count, input ready);
  modport sink (input valid, count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/hla_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hla_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/hla_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hla_cell #(
  parameter int THETA    = 0,
  parameter int RHO_BINS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire hla_pkg::hla_tok_t           tok_i,
  output hla_pkg::hla_tok_t                tok_o,
  input  wire hla_pkg::hla_res_t           res_i,
  output hla_pkg::hla_res_t                res_o,
  input  wire logic [9:0]                  rho_offset,
  input  wire logic                        clr_en,
  input  wire logic [$clog2(RHO_BINS)-1:0] clr_addr
);
  localparam int AW  = $clog2(RHO_BINS);
  localparam int BW  = (AW + 2 > 13) ? AW + 2 : 13;
  localparam int ANG = THETA - 90;
  localparam int MAG = (ANG < 0) ? -ANG : ANG;
  localparam logic [16:0] COS_C = 17'(hla_pkg::SIN_Q16[90 - MAG]);
  localparam logic [16:0] SIN_C = 17'(hla_pkg::SIN_Q16[MAG]);
  localparam bit NEG_SIN = (ANG < 0);

  hla_pkg::hla_tok_t tok_r;
  hla_pkg::hla_res_t res_r, res_nxt;
  logic [24:0] p_cos_r, p_sin_r;
  logic        vote_s1_r, vote_s2_r, vote_s2_nxt, rd_s1_r, rd_hit;
  logic [AW-1:0] waddr_s2_r;

  logic signed [26:0] sum;
  logic [26:0] mag, rnd_full;
  logic [10:0] rnd;
  logic [BW-1:0] ext, rho, biased;
  logic in_range;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [hla_pkg::COUNT_W-1:0] wdata, rdata;

  assign rd_hit = tok_i.valid && tok_i.rd && (tok_i.theta_index == 8'(THETA))
                  && (32'(tok_i.rho_index) < 32'(RHO_BINS));

  // rho = row*cos + col*sin, rounded half away from zero
  always_comb begin
    if (NEG_SIN) begin
      sum = $signed({2'b00, p_cos_r}) - $signed({2'b00, p_sin_r});
    end else begin
      sum = $signed({2'b00, p_cos_r}) + $signed({2'b00, p_sin_r});
    end
    mag      = sum[26] ? 27'(-sum) : 27'(sum);
    rnd_full = mag + 27'd32768;
    rnd      = rnd_full[26:16];
    ext      = BW'(rnd);
    rho      = sum[26] ? (~ext + BW'(1)) : ext;
    biased   = rho + BW'(rho_offset);
    in_range = !biased[BW-1] && (biased < BW'(RHO_BINS));
  end

  assign vote_s2_nxt = vote_s1_r && in_range;
  assign raddr = vote_s1_r ? biased[AW-1:0] : AW'(tok_i.rho_index);
  assign we    = clr_en || vote_s2_r;
  assign waddr = clr_en ? clr_addr : waddr_s2_r;
  assign wdata = clr_en ? '0 :
                 ((rdata == hla_pkg::COUNT_MAX) ? rdata : rdata + 1'b1);

  always_comb begin
    res_nxt = res_i;
    if (rd_s1_r) begin
      res_nxt.valid = 1'b1;
      res_nxt.count = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r     <= '0;
      res_r     <= '0;
      vote_s1_r <= 1'b0;
      vote_s2_r <= 1'b0;
      rd_s1_r   <= 1'b0;
    end else begin
      tok_r     <= tok_i;
      res_r     <= res_nxt;
      vote_s1_r <= tok_i.valid && tok_i.vote;
      vote_s2_r <= vote_s2_nxt;
      rd_s1_r   <= rd_hit;
    end
  end

  always_ff @(posedge clk) begin
    p_cos_r    <= 25'(tok_i.row) * 25'(COS_C);
    p_sin_r    <= 25'(tok_i.col) * 25'(SIN_C);
    waddr_s2_r <= biased[AW-1:0];
  end

  hla_ram #(.WIDTH(hla_pkg::COUNT_W), .DEPTH(RHO_BINS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign tok_o = tok_r;
  assign res_o = res_r;
endmodule
`default_nettype wire

@@ rtl/core/hough_line_accumulator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Hough line accumulator, rho/theta form. The store is split by angle into a chain of 181
// cells, each owning one RHO_BINS-deep column in its own RAM and a fixed cos/sin pair. One
// transaction is worked at a time: it walks the chain one cell per cycle, each cell doing a
// read-modify-write of its column for a vote, and the matching cell reading its column for a
// read. A clear transaction, and the pass after reset, write zeros to all columns in
// parallel, one row a cycle over all RHO_BINS rows (1024 by default), with in_chan.ready low.
// Config writes are taken any time but must only be issued while idle. A finished read waits
// in the output register while the next transaction is accepted.
`include "hough_line_accumulator_top_macros.svh"
module hough_line_accumulator_top #(
  parameter int RHO_BINS = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hla_in_if.sink     in_chan,
  hla_out_if.source  out_chan,
  input  wire logic  cfg_we,
  input  wire logic  cfg_index,
  input  wire logic [9:0] cfg_wdata
);
  localparam int AW  = $clog2(RHO_BINS);
  localparam int LAT = hla_pkg::ANGLE_STEPS + 3;
  localparam int CW  = $clog2(LAT + 1);

  hla_pkg::hla_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [CW-1:0] run_cnt_r;
  logic          is_read_r;
  logic [hla_pkg::COUNT_W-1:0] hold_r, out_count_r;
  logic          out_valid_r;
  logic [7:0]    mark_r;
  logic [9:0]    offset_r;
  hla_pkg::hla_tok_t tok0_r, tok0_nxt;

  // control outputs of the sequencer
  logic in_ready, clr_en, load_out, accept, clr_last, run_last;

  hla_pkg::hla_tok_t tok_chain [0:hla_pkg::ANGLE_STEPS];
  hla_pkg::hla_res_t res_chain [0:hla_pkg::ANGLE_STEPS];

  assign accept   = in_chan.valid && in_ready;
  assign clr_last = (32'(clr_cnt_r) == 32'(RHO_BINS - 1));
  assign run_last = (run_cnt_r == CW'(LAT - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hla_pkg::ST_CLEAR: if (clr_last) state_nxt = hla_pkg::ST_IDLE;
      hla_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_chan.func == hla_pkg::FUNC_CLEAR) ? hla_pkg::ST_CLEAR
                                                            : hla_pkg::ST_RUN;
        end
      end
      hla_pkg::ST_RUN: begin
        if (run_last) state_nxt = is_read_r ? hla_pkg::ST_DONE : hla_pkg::ST_IDLE;
      end
      hla_pkg::ST_DONE: if (!out_valid_r || out_chan.ready) state_nxt = hla_pkg::ST_IDLE;
      default: state_nxt = hla_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    clr_en   = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      hla_pkg::ST_CLEAR: clr_en = 1'b1;
      hla_pkg::ST_IDLE:  in_ready = 1'b1;
      hla_pkg::ST_RUN:   ;
      hla_pkg::ST_DONE:  load_out = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  // token launched into the first cell
  always_comb begin
    tok0_nxt             = '0;
    tok0_nxt.valid       = accept && (in_chan.func != hla_pkg::FUNC_CLEAR);
    tok0_nxt.vote        = (in_chan.func == hla_pkg::FUNC_VOTE)
                           && (in_chan.pixel == mark_r)
                           && (32'(in_chan.row) < 32'(hla_pkg::MAX_DIM))
                           && (32'(in_chan.col) < 32'(hla_pkg::MAX_DIM));
    tok0_nxt.rd          = (in_chan.func == hla_pkg::FUNC_READ);
    tok0_nxt.row         = in_chan.row;
    tok0_nxt.col         = in_chan.col;
    tok0_nxt.rho_index   = in_chan.rho_index;
    tok0_nxt.theta_index = in_chan.theta_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hla_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      run_cnt_r   <= '0;
      is_read_r   <= 1'b0;
      out_valid_r <= 1'b0;
      mark_r      <= hla_pkg::MARK_RESET;
      offset_r    <= hla_pkg::OFFSET_RESET;
      tok0_r      <= '0;
    end else begin
      state_r <= state_nxt;
      tok0_r  <= tok0_nxt;
      // clear sweep row counter
      if (accept) begin
        clr_cnt_r <= '0;
      end else if (clr_en) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      // chain walk timer
      if (accept) begin
        run_cnt_r <= '0;
        is_read_r <= (in_chan.func == hla_pkg::FUNC_READ);
      end else if (state_r == hla_pkg::ST_RUN) begin
        run_cnt_r <= run_cnt_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          hla_pkg::CFG_MARK_VALUE: mark_r   <= cfg_wdata[7:0];
          hla_pkg::CFG_RHO_OFFSET: offset_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // read result capture; stays zero when no cell matched (out-of-range read)
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= '0;
    end else if (res_chain[hla_pkg::ANGLE_STEPS].valid) begin
      hold_r <= res_chain[hla_pkg::ANGLE_STEPS].count;
    end
    if (load_out) begin
      out_count_r <= hold_r;
    end
  end

  assign tok_chain[0] = tok0_r;
  assign res_chain[0] = '0;

  // one cell per angle, theta index t is angle t - 90
  for (genvar t = 0; t < hla_pkg::ANGLE_STEPS; t++) begin : g_cell
    hla_cell #(.THETA(t), .RHO_BINS(RHO_BINS)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (tok_chain[t]),
      .tok_o      (tok_chain[t+1]),
      .res_i      (res_chain[t]),
      .res_o      (res_chain[t+1]),
      .rho_offset (offset_r),
      .clr_en     (clr_en),
      .clr_addr   (clr_cnt_r)
    );
  end

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.count = out_count_r;

  // a token or read result only leaves the chain while a transaction is in flight
  `HLA_ASSERT_SAME(a_tok_end_in_run, clk, rst_n, tok_chain[hla_pkg::ANGLE_STEPS].valid, state_r == hla_pkg::ST_RUN, "token left chain outside run")
  `HLA_ASSERT_SAME(a_res_end_in_run, clk, rst_n, res_chain[hla_pkg::ANGLE_STEPS].valid, (state_r == hla_pkg::ST_RUN) && is_read_r, "read result outside read run")
  // clear transaction starts the sweep from row zero
  `HLA_ASSERT_NEXT(a_clear_start, clk, rst_n, accept && (in_chan.func == hla_pkg::FUNC_CLEAR), (state_r == hla_pkg::ST_CLEAR) && (clr_cnt_r == '0), "clear did not start sweep")
  // a vote finishes without producing a result
  `HLA_ASSERT_NEXT(a_vote_done, clk, rst_n, (state_r == hla_pkg::ST_RUN) && run_last && !is_read_r, state_r == hla_pkg::ST_IDLE, "vote run did not return to idle")
endmodule
`default_nettype wire
